@@ hdl/markov_absorption_probability_unit_macros.svh @@
// Assertion helpers for the block's top module.
`ifndef MARKOV_ABSORPTION_PROBABILITY_UNIT_MACROS_SVH
`define MARKOV_ABSORPTION_PROBABILITY_UNIT_MACROS_SVH

// Check on every clock edge outside reset.
`define MAPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MAPU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mapu_pkg.sv @@
package mapu_pkg;

  localparam int ROW_W    = 6;
  localparam int COL_W    = 7;
  localparam int PROB_W   = 17;
  localparam int DIST_W   = 32;
  localparam int ACC_W    = 33;
  localparam int OUT_W    = 21;
  localparam int NUMST_W  = 7;
  localparam int ITER_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);
  localparam logic [DIST_W-1:0] ONE_Q31 = DIST_W'(64'h8000_0000);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);
  localparam logic [NUMST_W-1:0] NUMST_RESET = NUMST_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_STATES      = 2'd0,
    REG_ITERATION_COUNT = 2'd1
  } cfg_reg_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              init;
    logic              swap;
    logic              load_en;
    logic [ROW_W-1:0]  load_row;
    logic [PROB_W-1:0] load_prob;
    logic              res_en;
    logic [DIST_W-1:0] res_value;
  } cell_ctrl_t;

endpackage

@@ hdl/mapu_if.sv @@
interface mapu_in_if;
  logic                        valid;
  logic                        ready;
  logic [mapu_pkg::ROW_W-1:0]  from_state;
  logic [mapu_pkg::COL_W-1:0]  to_column;
  logic [mapu_pkg::PROB_W-1:0] probability;
  logic                        last;

  modport source(output valid, from_state, to_column, probability, last, input ready);
  modport sink(input valid, from_state, to_column, probability, last, output ready);
endinterface

interface mapu_out_if;
  logic                       valid;
  logic                       ready;
  logic [mapu_pkg::OUT_W-1:0] absorbed_probability;

  modport source(output valid, absorbed_probability, input ready);
  modport sink(input valid, absorbed_probability, output ready);
endinterface

@@ hdl/mapu_ram.sv @@
module mapu_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/mapu_cell.sv @@
module mapu_cell #(
  parameter int MAX_STATES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mapu_pkg::cell_ctrl_t                   ctrl,
  input  logic [$clog2(MAX_STATES+1)-1:0]        load_col,
  input  logic [$clog2(MAX_STATES+1)-1:0]        res_col,
  input  logic [$clog2(MAX_STATES+1)-1:0]        n,
  input  logic [$clog2(MAX_STATES)-1:0]          cell_index,
  input  logic                                   a_v_in,
  input  logic [$clog2(MAX_STATES+1)-1:0]        a_col_in,
  input  logic [48+$clog2(MAX_STATES)-1:0]       p_in,
  output logic                                   a_v_out,
  output logic [$clog2(MAX_STATES+1)-1:0]        a_col_out,
  output logic [48+$clog2(MAX_STATES)-1:0]       p_out
);
  import mapu_pkg::*;

  localparam int PSW  = 48 + $clog2(MAX_STATES);

  logic [DIST_W-1:0]        cur;
  logic [DIST_W-1:0]        nxt;
  logic [PROB_W-1:0]        rd;
  logic                     we;
  logic                     active;
  logic [DIST_W+PROB_W-1:0] prod;

  // Each cell owns one matrix row.
  assign we = ctrl.load_en && (32'(ctrl.load_row) == 32'(cell_index));

  mapu_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES+1)) u_row (
    .clk  (clk),
    .we   (we),
    .waddr(load_col),
    .wdata(ctrl.load_prob),
    .raddr(a_col_in),
    .rdata(rd)
  );

  // Rows past the state count add nothing, whatever their entries hold.
  assign active = (32'(cell_index) < 32'(n));
  assign prod   = active ? cur * rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v_out <= 1'b0;
      cur     <= (cell_index == '0) ? ONE_Q31 : '0;
    end else begin
      a_v_out <= a_v_in;
      if (ctrl.init) begin
        cur <= (cell_index == '0) ? ONE_Q31 : '0;
      end else if (ctrl.swap) begin
        cur <= nxt;
      end
    end
    a_col_out <= a_col_in;
    p_out     <= p_in + PSW'(prod);
    if (ctrl.res_en && (32'(res_col) == 32'(cell_index))) begin
      nxt <= ctrl.res_value;
    end
  end
endmodule

@@ hdl/markov_absorption_probability_unit.sv @@
// Absorption probability of a Markov chain, by repeated propagation.
// Channels: entry (sink) carries one transition-matrix entry per transfer:
// from_state, to_column, probability (Q1.16) and last. result (source) carries
// absorbed_probability in Q1.20. Configuration: cfg_we/cfg_index/cfg_data write
// num_states (index 0) and iteration_count (index 1) while the block is idle.
// Entries load at one per cycle while the block is idle. The entry marked
// last starts a run of iteration_count-1 steps; each step sends columns 0..n
// down a row of MAX_STATES cells, one column a cycle, each cell adding its
// state's mass times its row entry. A step ends once every column sum has
// left the chain, and the SWAP state then loads the new distribution; after
// the last step, the FINISH state hands the result on.
// The result sits in an output register; new entries are taken while it
// waits, and only a finishing run holds until the receiver takes it.
// Reset (rst, synchronous) restores num_states=1, iteration_count=1000 and the
// start distribution; matrix contents are kept unspecified until written.
module markov_absorption_probability_unit #(
  parameter int MAX_STATES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  mapu_in_if.sink                       entry,
  mapu_out_if.source                    result,
  input  logic                          cfg_we,
  input  logic [mapu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mapu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mapu_pkg::*;
  `include "markov_absorption_probability_unit_macros.svh"

  localparam int COLW = $clog2(MAX_STATES+1);
  localparam int IDXW = $clog2(MAX_STATES);
  localparam int PSW  = 48 + IDXW;

  typedef enum logic [1:0] {IDLE, RUN, SWAP, FINISH} state_t;

  state_t            state;
  logic [NUMST_W-1:0] num_states;
  logic [ITER_W-1:0]  iteration_count;
  logic [COLW-1:0]    n_reg;
  logic [COLW-1:0]    n_eff;
  logic [ITER_W-1:0]  steps;
  logic [ITER_W-1:0]  step;
  logic [COLW:0]      issue_col;
  logic [COLW:0]      rcv;
  logic [ACC_W-1:0]   absorbed;
  logic [ACC_W-1:0]   absorbed_next;
  logic               end_v;
  logic [COLW-1:0]    end_col;
  logic [PSW-17:0]    val_full;
  logic [DIST_W-1:0]  val;
  logic               out_free;
  logic               transfer;
  cell_ctrl_t         ctrl;

  logic               a_v   [MAX_STATES+1];
  logic [COLW-1:0]    a_col [MAX_STATES+1];
  logic [PSW-1:0]     p_sum [MAX_STATES+1];

  assign transfer    = entry.valid && entry.ready;
  assign entry.ready = (state == IDLE);
  assign out_free    = !result.valid || result.ready;

  // Clamp the state count into the supported range.
  always_comb begin
    if (num_states == '0) begin
      n_eff = COLW'(1);
    end else if (32'(num_states) > MAX_STATES) begin
      n_eff = COLW'(MAX_STATES);
    end else begin
      n_eff = COLW'(num_states);
    end
  end

  // Broadcast control for the cells.
  always_comb begin
    ctrl.init      = (state == FINISH) && out_free;
    ctrl.swap      = (state == SWAP);
    ctrl.load_en   = transfer && (32'(entry.from_state) < MAX_STATES)
                     && (32'(entry.to_column) <= MAX_STATES);
    ctrl.load_row  = entry.from_state;
    ctrl.load_prob = (entry.probability > ONE_Q16) ? ONE_Q16 : entry.probability;
    ctrl.res_en    = end_v && (end_col < n_reg);
    ctrl.res_value = val;
  end

  // Column sums leaving the chain: drop the Q1.16 scale and saturate.
  assign val_full = p_sum[MAX_STATES][PSW-1:16];
  assign val      = (val_full > (PSW-16)'(ONE_Q31)) ? ONE_Q31 : DIST_W'(val_full);

  always_comb begin
    absorbed_next = absorbed + ACC_W'(val);
    if (absorbed_next > ACC_W'(ONE_Q31)) begin
      absorbed_next = ACC_W'(ONE_Q31);
    end
  end

  // Head of the chain: feed the next column while the step has some left.
  assign a_v[0]   = (state == RUN) && (issue_col <= (COLW+1)'(n_reg));
  assign a_col[0] = issue_col[COLW-1:0];
  assign p_sum[0] = '0;

  for (genvar j = 0; j < MAX_STATES; j++) begin : g_cell
    mapu_cell #(.MAX_STATES(MAX_STATES)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_col  (COLW'(entry.to_column)),
      .res_col   (end_col),
      .n         (n_reg),
      .cell_index(IDXW'(j)),
      .a_v_in    (a_v[j]),
      .a_col_in  (a_col[j]),
      .p_in      (p_sum[j]),
      .a_v_out   (a_v[j+1]),
      .a_col_out (a_col[j+1]),
      .p_out     (p_sum[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      num_states      <= NUMST_RESET;
      iteration_count <= ITER_RESET;
      n_reg           <= COLW'(1);
      absorbed        <= '0;
      end_v           <= 1'b0;
      result.valid    <= 1'b0;
      issue_col       <= '0;
      rcv             <= '0;
      step            <= '0;
    end else begin
      // Align the column tag with the sum leaving the last cell.
      end_v <= a_v[MAX_STATES];
      if (result.valid && result.ready && !ctrl.init) begin
        result.valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_STATES:      num_states      <= cfg_data[NUMST_W-1:0];
          REG_ITERATION_COUNT: iteration_count <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (transfer && entry.last) begin
            n_reg     <= n_eff;
            steps     <= (iteration_count == '0) ? '0 : iteration_count - ITER_W'(1);
            step      <= '0;
            issue_col <= '0;
            rcv       <= '0;
            state     <= (iteration_count > ITER_W'(1)) ? RUN : FINISH;
          end
        end
        RUN: begin
          if (a_v[0]) begin
            issue_col <= issue_col + (COLW+1)'(1);
          end
          if (end_v) begin
            rcv <= rcv + (COLW+1)'(1);
            if (end_col == n_reg) begin
              absorbed <= absorbed_next;
            end
          end
          if (rcv == (COLW+1)'(n_reg) + (COLW+1)'(1)) begin
            state <= SWAP;
          end
        end
        SWAP: begin
          step      <= step + ITER_W'(1);
          issue_col <= '0;
          rcv       <= '0;
          state     <= (step + ITER_W'(1) == steps) ? FINISH : RUN;
        end
        FINISH: begin
          // Hold until the output register is free.
          if (out_free) begin
            result.valid                <= 1'b1;
            result.absorbed_probability <= absorbed[31:11];
            absorbed                    <= '0;
            state                       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    end_col <= a_col[MAX_STATES];
  end

  `MAPU_ASSERT(a_sum_in_run, end_v |-> state == RUN, "column sum outside a run")
  `MAPU_ASSERT(a_rcv_bound, rcv <= (COLW+1)'(n_reg) + (COLW+1)'(1), "too many column sums")
  `MAPU_ASSERT(a_finish_clear, ctrl.init |=> (absorbed == '0 && result.valid), "finish stalled")
  `MAPU_ASSERT(a_absorbed_sat, absorbed <= ACC_W'(ONE_Q31), "absorbed sum above one")
endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mapu_pkg::*;

  localparam int STATES = 64;
  localparam int COLS = STATES + 1;
  localparam int TOTAL_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 20;
  localparam int TAIL_CYCLES = 200;
  localparam int STALL_LIMIT = 1500000;
  localparam int IDLE_PCT = 34;
  localparam longint unsigned FULL_MASS = 64'h8000_0000;
  // Index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mapu_in_if in_ch();
  mapu_out_if out_ch();

  markov_absorption_probability_unit #(.MAX_STATES(STATES)) uut (
    .clk(clk),
    .rst(rst),
    .entry(in_ch),
    .result(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block: matrix, which entries hold a value, and the
  // two registers. The distribution is rebuilt on every run.
  logic [PROB_W-1:0] shadow_matrix [STATES][COLS];
  bit written [STATES][COLS];
  logic [NUMST_W-1:0] shadow_states = NUMST_RESET;
  logic [ITER_W-1:0] shadow_iters = ITER_RESET;

  logic [OUT_W-1:0] pending_absorbed [$];
  int errors = 0;
  int entries_moved = 0;
  int results_seen = 0;
  int runs_started = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [PROB_W-1:0]     prob;
    bit                    last;
    bit                    typed;
    logic [OUT_W-1:0]      absorbed;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void add_plan(plan_row_t p);
    plan = {plan, p};
  endfunction

  function automatic int active_states();
    if (shadow_states == 0) return 1;
    if (shadow_states > STATES) return STATES;
    return int'(shadow_states);
  endfunction

  // Mass arriving in one column from the current distribution, Q1.31.
  function automatic longint unsigned column_flow(longint unsigned mass [STATES], int n,
                                                  int col);
    longint unsigned acc;
    acc = 0;
    for (int j = 0; j < n; j++) acc += mass[j] * longint'(shadow_matrix[j][col]);
    acc = acc >> 16;
    return (acc > FULL_MASS) ? FULL_MASS : acc;
  endfunction

  function automatic logic [OUT_W-1:0] absorbed_after_run();
    longint unsigned mass [STATES];
    longint unsigned next_mass [STATES];
    longint unsigned absorbed;
    int n;
    int steps;
    n = active_states();
    steps = (shadow_iters > 0) ? int'(shadow_iters) - 1 : 0;
    absorbed = 0;
    foreach (mass[i]) mass[i] = 0;
    mass[0] = FULL_MASS;
    for (int k = 0; k < steps; k++) begin
      for (int i = 0; i < n; i++) next_mass[i] = column_flow(mass, n, i);
      absorbed += column_flow(mass, n, n);
      if (absorbed > FULL_MASS) absorbed = FULL_MASS;
      for (int i = 0; i < n; i++) mass[i] = next_mass[i];
    end
    return OUT_W'(absorbed >> 11);
  endfunction

  // Apply one accepted entry; returns 1 and the answer when it starts a run.
  function automatic bit absorb_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                      logic [PROB_W-1:0] prob, bit last,
                                      output logic [OUT_W-1:0] answer);
    logic [PROB_W-1:0] clipped;
    clipped = (prob > ONE_Q16) ? ONE_Q16 : prob;
    if (col <= STATES) begin
      shadow_matrix[row][col] = clipped;
      written[row][col] = 1'b1;
    end
    answer = '0;
    if (!last) return 1'b0;
    answer = absorbed_after_run();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Drive one entry and hold it until the transfer; queue any answer.
  task automatic send_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [PROB_W-1:0] prob, bit last, bit typed = 1'b0,
                            logic [OUT_W-1:0] typed_answer = '0);
    logic [OUT_W-1:0] answer;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.from_state <= row;
    in_ch.to_column <= col;
    in_ch.probability <= prob;
    in_ch.last <= last;
    do @(posedge clk); while (!in_ch.ready);
    entries_moved++;
    if (absorb_entry(row, col, prob, last, answer)) begin
      runs_started++;
      if (typed) answer = typed_answer;
      pending_absorbed = {pending_absorbed, answer};
    end
  endtask

  // Hold the sender until every answer is back, let the block settle, then write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_absorbed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_NUM_STATES) shadow_states = NUMST_W'(val);
    else if (idx == REG_ITERATION_COUNT) shadow_iters = ITER_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PROB_W-1:0] random_prob(int n);
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return ONE_Q16;
    if (pick < 33) return PROB_W'($urandom_range(131071, 65537));
    if (pick < 70) return PROB_W'($urandom_range(65536 / (n + 1)));
    return PROB_W'($urandom_range(65535));
  endfunction

  // Fill every entry a run will read that holds no value yet.
  task automatic cover_matrix();
    int n;
    n = active_states();
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++)
        if (!written[r][c]) send_entry(ROW_W'(r), COL_W'(c), random_prob(n), 1'b0);
  endtask

  task automatic random_entry(bit last);
    int n;
    n = active_states();
    if ($urandom_range(99) < 75)
      send_entry(ROW_W'($urandom_range(n - 1)), COL_W'($urandom_range(n)),
                 random_prob(n), last);
    else
      send_entry(ROW_W'($urandom_range(63)), COL_W'($urandom_range(127)),
                 random_prob(n), last);
  endtask

  function automatic plan_row_t entry_row(int row, int col, int prob, bit last,
                                          bit typed = 1'b0, int absorbed = 0);
    plan_row_t p;
    p = '{default: '0};
    p.row = ROW_W'(row);
    p.col = COL_W'(col);
    p.prob = PROB_W'(prob);
    p.last = last;
    p.typed = typed;
    p.absorbed = OUT_W'(absorbed);
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = CFG_DATA_W'(val);
    return p;
  endfunction

  // Result side: random back-pressure outside steady phases, checked against the oldest answer.
  always @(negedge clk)
    out_ch.ready <= rst ? 1'b0 : (steady || $urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_absorbed.size() == 0) begin
        report_mismatch("unexpected result", out_ch.absorbed_probability, -1);
      end else begin
        if (out_ch.absorbed_probability !== pending_absorbed[0])
          report_mismatch("absorbed_probability", out_ch.absorbed_probability,
                          pending_absorbed[0]);
        void'(pending_absorbed.pop_front());
      end
    end
  end

  // Watchdog: a long run moves nothing for a while, but never this long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    int n_pick;
    int settle;
    int phase;
    in_ch.valid <= 1'b0;
    in_ch.from_state <= '0;
    in_ch.to_column <= '0;
    in_ch.probability <= '0;
    in_ch.last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    foreach (written[r, c]) written[r][c] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Defaults after reset: one state, 1000 time points.
    add_plan(entry_row(0, 0, 0, 0));
    add_plan(entry_row(0, 1, 65536, 1, 1, 1048576));   // certain absorption
    add_plan(entry_row(0, 1, 131071, 1, 1, 1048576));  // above one, clipped
    add_plan(entry_row(0, 127, 0, 1, 1, 1048576));     // column past the store
    add_plan(entry_row(63, 64, 65536, 0));             // far corner of the store
    add_plan(entry_row(0, 65, 12345, 0));              // first column past the store
    add_plan(entry_row(0, 2, 7, 1, 1, 1048576));       // column n+1 is never read
    add_plan(entry_row(0, 1, 0, 1, 1, 0));             // mass leaks away
    add_plan(reg_row(REG_ITERATION_COUNT, 1));
    add_plan(entry_row(0, 1, 65536, 1, 1, 0));         // single time point
    add_plan(reg_row(REG_ITERATION_COUNT, 0));
    add_plan(entry_row(0, 0, 65536, 1, 1, 0));         // zero time points
    add_plan(reg_row(REG_ITERATION_COUNT, 2));
    add_plan(entry_row(0, 0, 32768, 0));
    add_plan(entry_row(0, 1, 32768, 1, 1, 524288));    // half absorbed in one step
    add_plan(reg_row(REG_SPARE, 4095));                // ignored register
    add_plan(entry_row(0, 1, 65536, 1, 1, 1048576));
    add_plan(reg_row(REG_NUM_STATES, 0));              // zero states act as one
    add_plan(entry_row(0, 1, 16384, 1, 1, 262144));
    add_plan(reg_row(REG_NUM_STATES, 2));
    add_plan(reg_row(REG_ITERATION_COUNT, 3));
    add_plan(entry_row(1, 0, 65536, 0));
    add_plan(entry_row(1, 1, 0, 0));
    add_plan(entry_row(1, 2, 65535, 1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_entry(plan[i].row, plan[i].col, plan[i].prob, plan[i].last,
                      plan[i].typed, plan[i].absorbed);
    end

    // Random part: small chains and short runs, new registers per phase.
    phase = 0;
    while (entries_moved < TOTAL_ITEMS) begin
      n_pick = $urandom_range(8, 0);
      target = $urandom_range(40, 0);
      write_reg(REG_NUM_STATES, CFG_DATA_W'(n_pick));
      write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(target));
      steady = (phase == 3);
      cover_matrix();
      settle = $urandom_range(60, 20);
      for (int k = 0; k < settle && entries_moved < TOTAL_ITEMS; k++)
        random_entry($urandom_range(99) < 5);
      random_entry(1'b1);
      phase++;
    end
    steady = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_absorbed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (results_seen != runs_started)
      report_mismatch("result count", results_seen, runs_started);
    $display("covered %0d entries and %0d runs in %0d phases of state count and length,",
             entries_moved, runs_started, phase);
    $display("with clipped, stray and ignored entries and stalls on both sides");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
